// ===== rtl/core/generation_tagged_page_slot_pool_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page slot pool
// Concurrent checks written once here; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef GENERATION_TAGGED_PAGE_SLOT_POOL_TOP_MACROS_SVH
`define GENERATION_TAGGED_PAGE_SLOT_POOL_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that cond holds at every clock edge outside reset.
`define GTPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("pool invariant violated");
// Check that cons holds in the same cycle as ante.
`define GTPS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pool implication violated");
`else
`define GTPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define GTPS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/gtps_pkg.sv =====
// ----------------------------------------------------------------------------
// gtps_pkg
// Shared types and codes of the generation tagged page slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package gtps_pkg;

    localparam int CNT_W    = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CHECK   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_POOL_EXH     = 3'd1,
        STAT_GEN_EXH      = 3'd2,
        STAT_STALE        = 3'd3,
        STAT_REL_MISMATCH = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_RESERVED  = 2'd1,
        SLOT_PUBLISHED = 2'd2
    } t_slot_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_SGL_EXEC,
        S_CHK_STK,
        S_CHK_MEM,
        S_CHK_TAG,
        S_POP_STK,
        S_POP_MEM,
        S_POP_WR
    } t_fsm;

    // Free stack controls.
    typedef struct packed {
        logic rd;
        logic push;
        logic drop;
    } t_stk_ctl;

    // Slot memory controls.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/generation_tagged_page_slot_pool_top.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_page_slot_pool_top
// Free list allocator of page slots with per-slot generation tags.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of its slot memory to free,
// generation zero, and holds s_axis_tready low meanwhile.
// Commands arrive one per transfer: reserve pops count slots from the free
// stack and bumps their generation, all or nothing; commit publishes one
// reserved slot; release returns a live slot to the stack; check tells
// whether a slot is published with the given generation. Every result
// carries the free, reserved, published and peak counters after the command.
// The steps follow from the slot memory and free stack memory, each with
// a registered read: commit, release and check read the slot on
// acceptance, act on it in S_SGL_EXEC and show the result from S_EMIT; a
// reserve rejected for its count or a short pool goes straight to S_EMIT;
// a reserve of N slots first scans the slots it would pop for an exhausted
// generation, each in S_CHK_STK, S_CHK_MEM and S_CHK_TAG, then pops and
// grants each slot in S_POP_STK, S_POP_MEM and S_POP_WR. A stalled output
// holds the sequencer. One command is worked at a time; the next is taken as
// soon as its final result sits in the output register, even while that
// result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generation_tagged_page_slot_pool_top_macros.svh"

module generation_tagged_page_slot_pool_top import gtps_pkg::*; #(
    parameter int SLOTS     = 1024,
    parameter int GEN_BITS  = 32,
    parameter int MAX_BATCH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input command stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, lowest bit up: count, slot, generation, zero fill
    input  wire logic [((CNT_W + $clog2(SLOTS) + GEN_BITS + 7) / 8) * 8 - 1:0]
                                                       s_axis_tdata,
    // tuser: command
    input  wire logic [CMD_W-1:0]                      s_axis_tuser,
    // result stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata, lowest bit up: slot_out, generation_out, free_count,
    // reserved_count, published_count, peak_count, zero fill
    output logic [(($clog2(SLOTS) + GEN_BITS + 4 * $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0]
                                                       m_axis_tdata,
    // tuser: status
    output logic [STATUS_W-1:0]                        m_axis_tuser,
    // tlast: final result of the command
    output logic                                       m_axis_tlast
);

    localparam int SW     = $clog2(SLOTS);
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int OUT_DW = ((SW + GEN_BITS + 4 * CW + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_fsm                r_state,  n_state;
    t_cmd                r_cmd,    n_cmd;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [SW-1:0]       r_slot,   n_slot;
    logic [GEN_BITS-1:0] r_gen,    n_gen;
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic [CW-1:0]       r_base,   n_base;
    logic [SW-1:0]       r_id,     n_id;

    logic [CW-1:0]       r_free_cnt,  n_free_cnt;
    logic [CW-1:0]       r_reserved,  n_reserved;
    logic [CW-1:0]       r_published, n_published;
    logic [CW-1:0]       r_peak,      n_peak;

    // pending single result, shown by the emit step
    t_status             r_res_status, n_res_status;
    logic [SW-1:0]       r_res_slot,   n_res_slot;
    logic [GEN_BITS-1:0] r_res_gen,    n_res_gen;

    // output register
    logic                r_out_valid,  n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [SW-1:0]       r_out_slot,   n_out_slot;
    logic [GEN_BITS-1:0] r_out_gen,    n_out_gen;
    logic                r_out_last,   n_out_last;
    logic [CW-1:0]       r_out_free,   n_out_free;
    logic [CW-1:0]       r_out_res,    n_out_res;
    logic [CW-1:0]       r_out_pub,    n_out_pub;
    logic [CW-1:0]       r_out_peak,   n_out_peak;

    // ------------------------------------------------------------------
    // Unpack the input and helpers
    // ------------------------------------------------------------------
    t_cmd                w_in_cmd;
    logic [CNT_W-1:0]    w_in_count;
    logic [SW-1:0]       w_in_slot;
    logic [GEN_BITS-1:0] w_in_gen;
    logic                w_in_fire;
    logic                w_out_free;
    logic                w_last_idx;
    logic                w_cnt_bad;
    logic                w_cnt_short;
    logic                w_slot_bad;
    logic [CW-1:0]       w_stk_pos;
    logic [CW-1:0]       w_new_res;
    logic [CW-1:0]       w_new_sum;

    assign w_in_cmd   = t_cmd'(s_axis_tuser);
    assign w_in_count = s_axis_tdata[CNT_W-1:0];
    assign w_in_slot  = s_axis_tdata[CNT_W +: SW];
    assign w_in_gen   = s_axis_tdata[CNT_W + SW +: GEN_BITS];

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_last_idx = (r_idx == r_count - 1'b1);

    assign w_cnt_bad   = (w_in_count == '0) || (32'(w_in_count) > MAX_BATCH);
    assign w_cnt_short = (32'(w_in_count) > 32'(r_free_cnt));
    assign w_slot_bad  = (32'(w_in_slot) >= SLOTS);

    // stack position of the slot popped at step r_idx
    assign w_stk_pos = r_base - CW'(1) - CW'(r_idx);
    assign w_new_res = r_reserved + CW'(r_count);
    assign w_new_sum = w_new_res + r_published;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    t_mem_ctl            w_mem_ctl;
    logic [SW-1:0]       w_mem_rd_addr;
    logic [SW-1:0]       w_mem_wr_addr;
    logic [GEN_BITS+1:0] w_mem_wr_data;
    logic [GEN_BITS+1:0] w_mem_rd_data;
    logic                w_mem_busy;
    t_slot_state         w_rd_state;
    logic [GEN_BITS-1:0] w_rd_tag;

    t_stk_ctl            w_stk_ctl;
    logic [SW-1:0]       w_stk_rd_id;
    logic [CW-1:0]       w_stk_top;

    logic                w_cmp_max;
    logic                w_tag_eq;
    logic [GEN_BITS-1:0] w_tag_inc;

    assign w_rd_state = t_slot_state'(w_mem_rd_data[GEN_BITS +: 2]);
    assign w_rd_tag   = w_mem_rd_data[GEN_BITS-1:0];
    assign w_cmp_max  = (r_state == S_CHK_TAG);

    gtps_slot_mem #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_mem_rd_addr),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .o_rd_data (w_mem_rd_data),
        .o_busy    (w_mem_busy)
    );

    gtps_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_stk_ctl),
        .i_rd_idx   (w_stk_pos[SW-1:0]),
        .i_push_id  (r_slot),
        .i_drop_cnt (r_count),
        .o_rd_id    (w_stk_rd_id),
        .o_top      (w_stk_top)
    );

    gtps_tag_unit #(
        .GEN_BITS (GEN_BITS)
    ) u_tag_unit (
        .i_tag     (w_rd_tag),
        .i_ref     (r_gen),
        .i_cmp_max (w_cmp_max),
        .o_eq      (w_tag_eq),
        .o_inc     (w_tag_inc)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (w_in_cmd == CMD_RESERVE) begin
                        n_state = (w_cnt_bad || w_cnt_short) ? S_EMIT : S_CHK_STK;
                    end else begin
                        n_state = w_slot_bad ? S_EMIT : S_SGL_EXEC;
                    end
                end
            end
            S_SGL_EXEC: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHK_STK: n_state = S_CHK_MEM;
            S_CHK_MEM: n_state = S_CHK_TAG;
            S_CHK_TAG: begin
                priority if (w_tag_eq) begin
                    n_state = S_EMIT;
                end else if (w_last_idx) begin
                    n_state = S_POP_STK;
                end else begin
                    n_state = S_CHK_STK;
                end
            end
            S_POP_STK: n_state = S_POP_MEM;
            S_POP_MEM: n_state = S_POP_WR;
            S_POP_WR: begin
                if (w_out_free) begin
                    n_state = w_last_idx ? S_IDLE : S_POP_STK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and controls
    // ------------------------------------------------------------------
    logic w_out_load;

    always_comb begin
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_slot       = r_slot;
        n_gen        = r_gen;
        n_idx        = r_idx;
        n_base       = r_base;
        n_id         = r_id;
        n_free_cnt   = r_free_cnt;
        n_reserved   = r_reserved;
        n_published  = r_published;
        n_peak       = r_peak;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_gen    = r_res_gen;

        w_mem_ctl     = '0;
        w_mem_rd_addr = w_in_slot;
        w_mem_wr_addr = r_slot;
        w_mem_wr_data = w_mem_rd_data;
        w_stk_ctl     = '0;

        w_out_load   = 1'b0;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_gen    = r_out_gen;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_cmd   = w_in_cmd;
                    n_count = w_in_count;
                    n_slot  = w_in_slot;
                    n_gen   = w_in_gen;
                    n_idx   = '0;
                    n_base  = r_free_cnt;
                    // fetch the addressed slot now for single-slot commands
                    w_mem_ctl.rd = 1'b1;
                    if (w_in_cmd == CMD_RESERVE) begin
                        n_res_slot = '0;
                        n_res_gen  = '0;
                        n_res_status = w_cnt_bad ? STAT_STALE : STAT_POOL_EXH;
                    end else begin
                        n_res_slot   = w_in_slot;
                        n_res_gen    = '0;
                        n_res_status = (w_in_cmd == CMD_RELEASE) ? STAT_REL_MISMATCH
                                                                 : STAT_STALE;
                    end
                end
            end
            S_SGL_EXEC: begin
                n_res_slot = r_slot;
                n_res_gen  = w_rd_tag;
                unique case (r_cmd)
                    CMD_COMMIT: begin
                        if (w_rd_state == SLOT_RESERVED && w_tag_eq) begin
                            w_mem_ctl.wr  = 1'b1;
                            w_mem_wr_data = {SLOT_PUBLISHED, w_rd_tag};
                            n_reserved    = r_reserved - 1'b1;
                            n_published   = r_published + 1'b1;
                            n_res_status  = STAT_OK;
                        end else begin
                            n_res_status = STAT_STALE;
                        end
                    end
                    CMD_RELEASE: begin
                        if (w_rd_state != SLOT_FREE && w_tag_eq &&
                            32'(r_free_cnt) < SLOTS) begin
                            w_mem_ctl.wr   = 1'b1;
                            w_mem_wr_data  = {SLOT_FREE, w_rd_tag};
                            w_stk_ctl.push = 1'b1;
                            n_free_cnt     = r_free_cnt + 1'b1;
                            if (w_rd_state == SLOT_RESERVED) begin
                                n_reserved = r_reserved - 1'b1;
                            end else begin
                                n_published = r_published - 1'b1;
                            end
                            n_res_status = STAT_OK;
                        end else begin
                            n_res_status = STAT_REL_MISMATCH;
                        end
                    end
                    CMD_CHECK: begin
                        n_res_status = (w_rd_state == SLOT_PUBLISHED && w_tag_eq)
                                       ? STAT_OK : STAT_STALE;
                    end
                    default: begin
                        n_res_status = STAT_STALE;
                    end
                endcase
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_gen    = r_res_gen;
                    n_out_last   = 1'b1;
                end
            end
            S_CHK_STK, S_POP_STK: begin
                w_stk_ctl.rd = 1'b1;
            end
            S_CHK_MEM, S_POP_MEM: begin
                w_mem_ctl.rd  = 1'b1;
                w_mem_rd_addr = w_stk_rd_id;
                n_id          = w_stk_rd_id;
            end
            S_CHK_TAG: begin
                if (w_tag_eq) begin
                    // a slot on the pop path is at its largest generation
                    n_res_status = STAT_GEN_EXH;
                    n_res_slot   = r_id;
                    n_res_gen    = w_rd_tag;
                end else if (w_last_idx) begin
                    // scan passed: book the whole reserve before granting
                    n_idx      = '0;
                    n_free_cnt = r_free_cnt - CW'(r_count);
                    n_reserved = w_new_res;
                    if (w_new_sum > r_peak) begin
                        n_peak = w_new_sum;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_POP_WR: begin
                if (w_out_free) begin
                    w_mem_ctl.wr  = 1'b1;
                    w_mem_wr_addr = r_id;
                    w_mem_wr_data = {SLOT_RESERVED, w_tag_inc};
                    w_out_load    = 1'b1;
                    n_out_status  = STAT_OK;
                    n_out_slot    = r_id;
                    n_out_gen     = w_tag_inc;
                    n_out_last    = w_last_idx;
                    if (w_last_idx) begin
                        w_stk_ctl.drop = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // counters shown with every result are the ones after the command
    always_comb begin
        n_out_free  = r_out_free;
        n_out_res   = r_out_res;
        n_out_pub   = r_out_pub;
        n_out_peak  = r_out_peak;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out_free  = r_free_cnt;
            n_out_res   = r_reserved;
            n_out_pub   = r_published;
            n_out_peak  = r_peak;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_cnt  <= CW'(SLOTS);
            r_reserved  <= '0;
            r_published <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_cnt  <= n_free_cnt;
            r_reserved  <= n_reserved;
            r_published <= n_published;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_count      <= n_count;
        r_slot       <= n_slot;
        r_gen        <= n_gen;
        r_idx        <= n_idx;
        r_base       <= n_base;
        r_id         <= n_id;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_gen    <= n_res_gen;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_gen    <= n_out_gen;
        r_out_last   <= n_out_last;
        r_out_free   <= n_out_free;
        r_out_res    <= n_out_res;
        r_out_pub    <= n_out_pub;
        r_out_peak   <= n_out_peak;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE) && !w_mem_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_DW'({r_out_peak, r_out_pub, r_out_res, r_out_free,
                                    r_out_gen, r_out_slot});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every slot is free, reserved or published
    `GTPS_ASSERT_ALWAYS(a_slots_conserved, i_clk, i_rst_n, (32'(r_free_cnt) + 32'(r_reserved) + 32'(r_published) == SLOTS))
    // peak never falls below the live total
    `GTPS_ASSERT_ALWAYS(a_peak_covers_live, i_clk, i_rst_n, (32'(r_peak) >= 32'(r_reserved) + 32'(r_published)))
    // between commands the stack top agrees with the free counter
    `GTPS_ASSERT_IMPLY(a_stack_top_sync, i_clk, i_rst_n, (r_state == S_IDLE), (w_stk_top == r_free_cnt))

endmodule

`default_nettype wire

// ===== rtl/core/gtps_tag_unit.sv =====
// ----------------------------------------------------------------------------
// gtps_tag_unit
// Shared generation compare and increment unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gtps_tag_unit import gtps_pkg::*; #(
    parameter int GEN_BITS = 32
) (
    input  wire logic [GEN_BITS-1:0] i_tag,
    input  wire logic [GEN_BITS-1:0] i_ref,
    input  wire logic                i_cmp_max,
    output logic                     o_eq,
    output logic [GEN_BITS-1:0]      o_inc
);

    logic [GEN_BITS-1:0] w_operand;

    // compare against the largest tag or the requester's tag
    assign w_operand = i_cmp_max ? {GEN_BITS{1'b1}} : i_ref;
    assign o_eq      = (i_tag == w_operand);
    assign o_inc     = i_tag + {{(GEN_BITS-1){1'b0}}, 1'b1};

endmodule

`default_nettype wire

// ===== rtl/core/gtps_slot_mem.sv =====
// ----------------------------------------------------------------------------
// gtps_slot_mem
// Slot state and generation memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gtps_slot_mem import gtps_pkg::*; #(
    parameter int SLOTS    = 1024,
    parameter int GEN_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_mem_ctl                   i_ctl,
    input  wire logic [$clog2(SLOTS)-1:0]   i_rd_addr,
    input  wire logic [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  wire logic [GEN_BITS+1:0]        i_wr_data,
    output logic [GEN_BITS+1:0]             o_rd_data,
    output logic                            o_busy
);

    localparam int SW = $clog2(SLOTS);

    logic [GEN_BITS+1:0] r_mem [SLOTS];
    logic [GEN_BITS+1:0] r_rd_q;
    logic                r_clr_active;
    logic [SW-1:0]       r_clr_addr;

    logic                w_wr_en;
    logic [SW-1:0]       w_wr_addr;
    logic [GEN_BITS+1:0] w_wr_data;

    // sweep every entry to free with tag zero before serving requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (32'(r_clr_addr) == SLOTS - 1) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_active) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = {SLOT_FREE, {GEN_BITS{1'b0}}};
        end else begin
            w_wr_en   = i_ctl.wr;
            w_wr_addr = i_wr_addr;
            w_wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_q;
    assign o_busy    = r_clr_active;

endmodule

`default_nettype wire

// ===== rtl/core/gtps_free_stack.sv =====
// ----------------------------------------------------------------------------
// gtps_free_stack
// LIFO of free slot ids; entries below the low mark read their reset id.
// ----------------------------------------------------------------------------
`default_nettype none

module gtps_free_stack import gtps_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_stk_ctl                     i_ctl,
    input  wire logic [$clog2(SLOTS)-1:0]     i_rd_idx,
    input  wire logic [$clog2(SLOTS)-1:0]     i_push_id,
    input  wire logic [CNT_W-1:0]             i_drop_cnt,
    output logic [$clog2(SLOTS)-1:0]          o_rd_id,
    output logic [$clog2(SLOTS+1)-1:0]        o_top
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SW-1:0] r_mem [SLOTS];
    logic [SW-1:0] r_mem_q;
    logic [SW-1:0] r_init_id;
    logic          r_use_init;
    logic [CW-1:0] r_top;
    logic [CW-1:0] r_min_top;
    logic [CW-1:0] n_top;
    logic [CW-1:0] n_min_top;

    // an index below the lowest top ever reached was never written
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_top[SW-1:0]] <= i_push_id;
        end
        if (i_ctl.rd) begin
            r_mem_q    <= r_mem[i_rd_idx];
            r_use_init <= (CW'(i_rd_idx) < r_min_top);
            r_init_id  <= SW'(SLOTS - 1) - i_rd_idx;
        end
    end

    always_comb begin
        n_top     = r_top;
        n_min_top = r_min_top;
        if (i_ctl.push) begin
            n_top = r_top + 1'b1;
        end else if (i_ctl.drop) begin
            n_top = r_top - CW'(i_drop_cnt);
            if (n_top < r_min_top) begin
                n_min_top = n_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= CW'(SLOTS);
            r_min_top <= CW'(SLOTS);
        end else begin
            r_top     <= n_top;
            r_min_top <= n_min_top;
        end
    end

    assign o_rd_id = r_use_init ? r_init_id : r_mem_q;
    assign o_top   = r_top;

endmodule

`default_nettype wire

// ===== verif/generation_tagged_page_slot_pool_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generation_tagged_page_slot_pool_top_tb
// Self-checking bench for the page slot pool. A shadow copy of the pool
// (slot phases, generation tags, free stack and counters) is advanced on
// every accepted command and queues the results it predicts. Each result
// leaving the block is compared, field by field, with the oldest prediction.
// A directed opening walks every command and reject path bar generation
// exhaustion and drains the pool empty. Random phases follow, mostly valid
// handles with random noise mixed in, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module generation_tagged_page_slot_pool_top_tb;
    import gtps_pkg::*;

    localparam int SLOTS            = 1024;
    localparam int GEN_BITS         = 32;
    localparam int MAX_BATCH        = 64;
    localparam int SLOT_W           = $clog2(SLOTS);
    localparam int COUNT_W          = $clog2(SLOTS + 1);
    localparam int S_DATA_W         = ((CNT_W + SLOT_W + GEN_BITS + 7) / 8) * 8;
    localparam int M_DATA_W         = ((SLOT_W + GEN_BITS + 4 * COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int RANDOM_PER_PHASE = 86;
    localparam int HOLD_AT          = 60;   // commands accepted when the long hold-off starts
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 30;
    localparam logic [GEN_BITS-1:0] GEN_TOP = '1;

    typedef struct packed {
        t_cmd                cmd;
        logic [CNT_W-1:0]    count;
        logic [SLOT_W-1:0]   slot;
        logic [GEN_BITS-1:0] gen;
    } pool_cmd_t;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [GEN_BITS-1:0] gen;
        logic                last;
        logic [COUNT_W-1:0]  free_n;
        logic [COUNT_W-1:0]  reserved_n;
        logic [COUNT_W-1:0]  published_n;
        logic [COUNT_W-1:0]  peak_n;
    } pool_result_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // count, slot, generation, zero fill (lowest bit up)
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // command
    logic [CMD_W-1:0]    s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // slot_out, generation_out, free, reserved, published, peak, zero fill
    logic [M_DATA_W-1:0] m_axis_tdata;
    // status
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    generation_tagged_page_slot_pool_top #(
        .SLOTS     (SLOTS),
        .GEN_BITS  (GEN_BITS),
        .MAX_BATCH (MAX_BATCH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow pool
    t_slot_state         slot_phase [SLOTS];
    logic [GEN_BITS-1:0] slot_gen   [SLOTS];
    logic [SLOT_W-1:0]   free_stack [SLOTS];
    int                  free_top;
    int                  reserved_total;
    int                  published_total;
    int                  peak_total;

    pool_cmd_t    pending_cmds[$];
    pool_result_t expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int status_seen[5] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void pool_reset();
        for (int i = 0; i < SLOTS; i++) begin
            slot_phase[i] = SLOT_FREE;
            slot_gen[i]   = '0;
            free_stack[i] = SLOT_W'(SLOTS - 1 - i);
        end
        free_top        = SLOTS;
        reserved_total  = 0;
        published_total = 0;
        peak_total      = 0;
    endfunction

    // Append one command to the driver's queue.
    function automatic void enqueue_cmd(pool_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // Queue one prediction; the counters are taken as they stand after the step.
    function automatic void post_result(t_status st, logic [SLOT_W-1:0] slot,
                                        logic [GEN_BITS-1:0] gen, logic last);
        pool_result_t r;
        r.status      = st;
        r.slot        = slot;
        r.gen         = gen;
        r.last        = last;
        r.free_n      = COUNT_W'(free_top);
        r.reserved_n  = COUNT_W'(reserved_total);
        r.published_n = COUNT_W'(published_total);
        r.peak_n      = COUNT_W'(peak_total);
        expected_results = {expected_results, r};
    endfunction

    function automatic void pool_apply(pool_cmd_t c);
        int                n;
        int                base;
        bit                stuck;
        bit                hit;
        logic [SLOT_W-1:0] id;
        t_status           st;
        if (c.cmd == CMD_RESERVE) begin
            n = int'(c.count);
            if (n == 0 || n > MAX_BATCH) begin
                post_result(STAT_STALE, '0, '0, 1'b1);
            end else if (n > free_top) begin
                post_result(STAT_POOL_EXH, '0, '0, 1'b1);
            end else begin
                // All or nothing: scan the slots to be popped for a tag at its top first.
                stuck = 1'b0;
                for (int i = 0; i < n && !stuck; i++) begin
                    id = free_stack[free_top - 1 - i];
                    if (slot_gen[id] == GEN_TOP) begin
                        stuck = 1'b1;
                        post_result(STAT_GEN_EXH, id, slot_gen[id], 1'b1);
                    end
                end
                if (!stuck) begin
                    base            = free_top;
                    free_top        = base - n;
                    reserved_total += n;
                    if (reserved_total + published_total > peak_total)
                        peak_total = reserved_total + published_total;
                    for (int i = 0; i < n; i++) begin
                        id             = free_stack[base - 1 - i];
                        slot_phase[id] = SLOT_RESERVED;
                        slot_gen[id]   = slot_gen[id] + 1'b1;
                        post_result(STAT_OK, id, slot_gen[id], i == n - 1);
                    end
                end
            end
        end else begin
            id  = c.slot;
            hit = (slot_gen[id] == c.gen);
            if (c.cmd == CMD_COMMIT) begin
                if (slot_phase[id] == SLOT_RESERVED && hit) begin
                    slot_phase[id] = SLOT_PUBLISHED;
                    reserved_total--;
                    published_total++;
                    st = STAT_OK;
                end else begin
                    st = STAT_STALE;
                end
            end else if (c.cmd == CMD_RELEASE) begin
                if (slot_phase[id] != SLOT_FREE && hit && free_top < SLOTS) begin
                    if (slot_phase[id] == SLOT_RESERVED)
                        reserved_total--;
                    else
                        published_total--;
                    slot_phase[id]       = SLOT_FREE;
                    free_stack[free_top] = id;
                    free_top++;
                    st = STAT_OK;
                end else begin
                    st = STAT_REL_MISMATCH;
                end
            end else begin
                st = (slot_phase[id] == SLOT_PUBLISHED && hit) ? STAT_OK : STAT_STALE;
            end
            post_result(st, id, slot_gen[id], 1'b1);
        end
    endfunction

    // Find a slot in the wanted phase (or any live one), starting at a random index.
    function automatic logic [SLOT_W-1:0] find_slot(bit any_live, t_slot_state want);
        int start;
        int idx;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            idx = (start + k) % SLOTS;
            if (any_live ? (slot_phase[idx] != SLOT_FREE) : (slot_phase[idx] == want))
                return SLOT_W'(idx);
        end
        return SLOT_W'(start);
    endfunction

    function automatic pool_cmd_t directed_cmd(t_cmd cmd, int count, int slot,
                                               logic [GEN_BITS-1:0] gen);
        pool_cmd_t c;
        c.cmd   = cmd;
        c.count = CNT_W'(count);
        c.slot  = SLOT_W'(slot);
        c.gen   = gen;
        return c;
    endfunction

    // Mostly live handles with the right tag; the rest is noise and bent tags.
    function automatic pool_cmd_t random_cmd();
        pool_cmd_t c;
        int        pick;
        int        release_cut;
        int        r;
        c.cmd   = CMD_RESERVE;
        c.count = CNT_W'($urandom);
        c.slot  = SLOT_W'($urandom);
        c.gen   = $urandom;
        if ($urandom_range(99) < 10) begin
            c.cmd = t_cmd'($urandom_range(3));
            return c;
        end
        release_cut = (free_top < 256) ? 40 : 25;
        pick        = $urandom_range(99);
        if (pick < 30) begin
            r = $urandom_range(99);
            if (r < 4)
                c.count = ($urandom_range(1) != 0) ? '0 : CNT_W'($urandom_range(127, 65));
            else if (r < 12)
                c.count = CNT_W'($urandom_range(MAX_BATCH, 33));
            else
                c.count = CNT_W'($urandom_range(8, 1));
            return c;
        end
        if (pick < 50) begin
            c.cmd  = CMD_COMMIT;
            c.slot = find_slot(1'b0, SLOT_RESERVED);
        end else if (pick < 50 + release_cut) begin
            c.cmd  = CMD_RELEASE;
            c.slot = find_slot(1'b1, SLOT_FREE);
        end else begin
            c.cmd  = CMD_CHECK;
            c.slot = find_slot(1'b0, SLOT_PUBLISHED);
        end
        r = $urandom_range(99);
        if (r < 88)
            c.gen = slot_gen[c.slot];
        else if (r < 96)
            c.gen = slot_gen[c.slot] ^ (GEN_BITS'(1) << $urandom_range(GEN_BITS - 1));
        return c;
    endfunction

    // Driver: present the next pending command once the previous transfer is done.
    always @(posedge i_clk) begin
        pool_cmd_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_DATA_W'({nxt.gen, nxt.slot, nxt.count});
                s_axis_tuser  <= nxt.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && cmds_accepted == HOLD_AT) begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Input monitor: advance the shadow pool on each accepted command.
    always @(posedge i_clk) begin
        pool_cmd_t c;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            c.cmd   = t_cmd'(s_axis_tuser);
            c.count = s_axis_tdata[0 +: CNT_W];
            c.slot  = s_axis_tdata[CNT_W +: SLOT_W];
            c.gen   = s_axis_tdata[CNT_W + SLOT_W +: GEN_BITS];
            pool_apply(c);
            cmds_accepted <= cmds_accepted + 1;
        end
    end

    // Output monitor: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        pool_result_t got;
        pool_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status      = t_status'(m_axis_tuser);
            got.slot        = m_axis_tdata[0 +: SLOT_W];
            got.gen         = m_axis_tdata[SLOT_W +: GEN_BITS];
            got.last        = m_axis_tlast;
            got.free_n      = m_axis_tdata[SLOT_W + GEN_BITS +: COUNT_W];
            got.reserved_n  = m_axis_tdata[SLOT_W + GEN_BITS + COUNT_W +: COUNT_W];
            got.published_n = m_axis_tdata[SLOT_W + GEN_BITS + 2 * COUNT_W +: COUNT_W];
            got.peak_n      = m_axis_tdata[SLOT_W + GEN_BITS + 3 * COUNT_W +: COUNT_W];
            results_seen++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: st=%0d slot=%0d gen=%h last=%b",
                             $time, got.status, got.slot, got.gen, got.last);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (want.status <= STAT_REL_MISMATCH)
                    status_seen[int'(want.status)]++;
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("[%0t] result mismatch", $time);
                        $display("  exp st=%0d slot=%0d gen=%h last=%b cnt=%0d/%0d/%0d/%0d",
                                 want.status, want.slot, want.gen, want.last, want.free_n,
                                 want.reserved_n, want.published_n, want.peak_n);
                        $display("  got st=%0d slot=%0d gen=%h last=%b cnt=%0d/%0d/%0d/%0d",
                                 got.status, got.slot, got.gen, got.last, got.free_n,
                                 got.reserved_n, got.published_n, got.peak_n);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        pool_reset();

        // Directed opening: one slot through every command and reject path but generation exhaustion.
        enqueue_cmd(directed_cmd(CMD_RESERVE, 1, 0, '0));
        enqueue_cmd(directed_cmd(CMD_COMMIT, 0, 0, GEN_TOP));  // stale tag
        enqueue_cmd(directed_cmd(CMD_CHECK, 0, 0, 32'd1));     // reserved only
        enqueue_cmd(directed_cmd(CMD_COMMIT, 0, 0, 32'd1));
        enqueue_cmd(directed_cmd(CMD_COMMIT, 0, 0, 32'd1));    // already published
        enqueue_cmd(directed_cmd(CMD_CHECK, 0, 0, 32'd1));
        enqueue_cmd(directed_cmd(CMD_RELEASE, 0, 0, '0));       // tag mismatch
        enqueue_cmd(directed_cmd(CMD_RELEASE, 0, 0, 32'd1));
        enqueue_cmd(directed_cmd(CMD_RELEASE, 0, 0, 32'd1));    // slot already free
        enqueue_cmd(directed_cmd(CMD_RESERVE, 0, SLOTS - 1, GEN_TOP));
        enqueue_cmd(directed_cmd(CMD_RESERVE, 127, 0, '0));
        // Empty the free stack in full batches, then ask for one more slot.
        // Generation exhaustion needs 2^32 reserves of one slot and stays out of reach.
        for (int i = 0; i < SLOTS / MAX_BATCH; i++)
            enqueue_cmd(directed_cmd(CMD_RESERVE, MAX_BATCH, 0, '0));
        enqueue_cmd(directed_cmd(CMD_RESERVE, 1, 0, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            // Feed one command at a time so each pick sees a near-current pool.
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                while (pending_cmds.size() != 0)
                    @(negedge i_clk);
                enqueue_cmd(random_cmd());
            end
            // Hold the sender until every predicted result has come back.
            while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
                @(negedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatches += expected_results.size();

        $display("covered %0d commands, %0d results: ok %0d, pool exhausted %0d, stale %0d,",
                 cmds_accepted, results_seen, status_seen[STAT_OK],
                 status_seen[STAT_POOL_EXH], status_seen[STAT_STALE]);
        $display("release mismatch %0d; peak occupancy %0d of %0d slots",
                 status_seen[STAT_REL_MISMATCH], peak_total, SLOTS);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gtps_pkg.sv
rtl/core/gtps_tag_unit.sv
rtl/core/gtps_slot_mem.sv
rtl/core/gtps_free_stack.sv
rtl/core/generation_tagged_page_slot_pool_top.sv
verif/generation_tagged_page_slot_pool_top_tb.sv
